@@ hdl/hbdn_pkg.sv @@
package hbdn_pkg;

	localparam int NCAND = 64;
	localparam int CIDX_W = $clog2(NCAND);
	localparam int ROT_CYCLES = 2 * NCAND;
	localparam int ROT_W = $clog2(ROT_CYCLES);
	// register stages in the overlap pipe, from the head cell to the hit
	localparam int CMP_LAT = 4;
	localparam int HEAT_FRAC_BITS = 4;

	localparam logic signed [19:0] BOX_MAX = 20'sd524287;
	localparam logic signed [19:0] BOX_MIN = -20'sd524288;

	// exp(-2^-f) in Q0.32 for f = 0..7
	localparam logic [31:0] EXP_TAB [8] = '{
		32'd1580030169, 32'd2605029347, 32'd3344923893, 32'd3790295335,
		32'd4034748381, 32'd4162825045, 32'd4228380001, 32'd4261544025};

	localparam logic [2:0] CFG_CONF_THR = 3'd0;
	localparam logic [2:0] CFG_NMS_THR  = 3'd1;
	localparam logic [2:0] CFG_INV_W    = 3'd2;
	localparam logic [2:0] CFG_INV_H    = 3'd3;
	localparam logic [2:0] CFG_GRID_W   = 3'd4;
	localparam logic [2:0] CFG_GRID_H   = 3'd5;
	localparam logic [2:0] CFG_OFS_FRAC = 3'd6;
	localparam logic [2:0] CFG_SIZ_FRAC = 3'd7;

	typedef struct packed {
		logic              vld;
		logic              sup;
		logic signed [19:0] left;
		logic signed [19:0] top;
		logic signed [19:0] width;
		logic signed [19:0] height;
		logic signed [7:0]  logit;
		logic [15:0]        src_idx;
	} cand_t;

	typedef struct packed {
		logic  vld;
		logic  cand;
		logic  last;
		cand_t ent;
	} dec_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_POP,
		OP_ROT
	} chain_op_t;

	typedef enum logic [3:0] {
		S_FILL = 4'b0001,
		S_HEAD = 4'b0010,
		S_ROT  = 4'b0100,
		S_DONE = 4'b1000
	} nms_state_t;

	typedef logic [15:0] sig_tab_t [256];

	function automatic logic [15:0] sig_q16(input int l);
		logic [63:0] p;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] num;
		logic [63:0] q;
		logic [63:0] rem;
		int n;
		n = (l < 0) ? -l : l;
		e = {32'd0, EXP_TAB[HEAT_FRAC_BITS]};
		p = 64'h1_0000_0000;
		for (int i = 0; i < n; i++)
			p = (p * e) >> 32;
		d = 64'h1_0000_0000 + p;
		num = (l >= 0) ? (64'd1 << 48) : (p << 16);
		num = num + (d >> 1);
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= d) begin
				rem = rem - d;
				q[b] = 1'b1;
			end
		end
		return (q > 64'd65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic sig_tab_t build_sig_tab();
		sig_tab_t t;
		for (int i = 0; i < 256; i++)
			t[i] = sig_q16((i >= 128) ? i - 256 : i);
		return t;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

	// floor((p*4 + 2^15) / 2^16), saturated to Q3.16
	function automatic logic signed [19:0] norm_sat(input logic signed [43:0] p);
		logic signed [43:0] v;
		v = (p + 44'sd8192) >>> 14;
		if (v > 44'sd524287)
			return BOX_MAX;
		else if (v < -44'sd524288)
			return BOX_MIN;
		else
			return v[19:0];
	endfunction

endpackage

@@ hdl/hbdn_cell.sv @@
module hbdn_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  hbdn_pkg::chain_op_t op,
	input  hbdn_pkg::cand_t   new_ent,
	input  hbdn_pkg::cand_t   prev_ent,
	input  logic              prev_above,
	input  hbdn_pkg::cand_t   next_ent,
	input  logic              sup_hit,
	output hbdn_pkg::cand_t   ent,
	output logic              above
);
	import hbdn_pkg::*;

	cand_t ent_q;
	cand_t nxt;

	// strict compare keeps equal logits in arrival order
	assign above = ent_q.vld && (ent_q.logit < new_ent.logit);
	assign ent = ent_q;

	always_comb begin
		nxt = ent_q;
		case (op)
			OP_INS: begin
				if (prev_above)
					nxt = prev_ent;
				else if (prev_ent.vld && (above || !ent_q.vld))
					nxt = new_ent;
			end
			OP_POP: nxt = next_ent;
			OP_ROT: begin
				nxt = next_ent;
				nxt.sup = next_ent.sup | sup_hit;
			end
			default: nxt = ent_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ent_q <= '0;
		else
			ent_q <= nxt;
	end

endmodule

@@ hdl/hbdn_decode.sv @@
module hbdn_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic signed [7:0] heat_logit,
	input  logic signed [7:0] offset_x,
	input  logic signed [7:0] offset_y,
	input  logic signed [7:0] size_x,
	input  logic signed [7:0] size_y,
	input  logic              last_cell,
	input  logic signed [7:0] conf_thr,
	input  logic [23:0]       inv_w,
	input  logic [23:0]       inv_h,
	input  logic [8:0]        grid_w,
	input  logic [8:0]        grid_h,
	input  logic [2:0]        ofs_frac,
	input  logic [2:0]        siz_frac,
	output hbdn_pkg::dec_t    dec
);
	import hbdn_pkg::*;

	logic [7:0]  col_q, row_q;
	logic [16:0] cell_d;
	logic [8:0]  gw_eff, gh_eff;
	logic [3:0]  osh, ssh_h, ssh_f;
	logic signed [15:0] ox16, oy16, sxh16, syh16, sxf16, syf16;
	logic signed [17:0] cx, cy;

	logic signed [18:0] gl_s1, gt_s1, gw_s1, gh_s1;
	logic               vld_s1, cand_s1, last_s1;
	logic signed [7:0]  logit_s1;
	logic [15:0]        cell_s1;

	logic signed [43:0] pl_s2, pt_s2, pw_s2, ph_s2;
	logic               vld_s2, cand_s2, last_s2;
	logic signed [7:0]  logit_s2;
	logic [15:0]        cell_s2;

	dec_t dec_s3;

	assign gw_eff = (grid_w == 9'd0) ? 9'd1 : ((grid_w > 9'd256) ? 9'd256 : grid_w);
	assign gh_eff = (grid_h == 9'd0) ? 9'd1 : ((grid_h > 9'd256) ? 9'd256 : grid_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (last_cell) begin
				col_q <= '0;
				row_q <= '0;
			end else if ({1'b0, col_q} + 9'd1 >= gw_eff) begin
				col_q <= '0;
				if ({1'b0, row_q} + 9'd1 >= gh_eff)
					row_q <= '0;
				else
					row_q <= row_q + 8'd1;
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
	end

	// row * width + column, at most 65535
	assign cell_d = {9'd0, row_q} * {8'd0, gw_eff} + {9'd0, col_q};

	// grid units in Q.8
	assign osh   = 4'd8 - {1'b0, ofs_frac};
	assign ssh_h = 4'd7 - {1'b0, siz_frac};
	assign ssh_f = 4'd8 - {1'b0, siz_frac};
	assign ox16  = $signed({{8{offset_x[7]}}, offset_x}) <<< osh;
	assign oy16  = $signed({{8{offset_y[7]}}, offset_y}) <<< osh;
	assign sxh16 = $signed({{8{size_x[7]}}, size_x}) <<< ssh_h;
	assign syh16 = $signed({{8{size_y[7]}}, size_y}) <<< ssh_h;
	assign sxf16 = $signed({{8{size_x[7]}}, size_x}) <<< ssh_f;
	assign syf16 = $signed({{8{size_y[7]}}, size_y}) <<< ssh_f;
	assign cx = $signed({2'b00, col_q, 8'h00}) + $signed({{2{ox16[15]}}, ox16});
	assign cy = $signed({2'b00, row_q, 8'h00}) + $signed({{2{oy16[15]}}, oy16});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			dec_s3 <= '0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			dec_s3.vld            <= vld_s2;
			dec_s3.cand           <= cand_s2;
			dec_s3.last           <= last_s2;
			dec_s3.ent.vld        <= 1'b1;
			dec_s3.ent.sup        <= 1'b0;
			dec_s3.ent.left       <= norm_sat(pl_s2);
			dec_s3.ent.top        <= norm_sat(pt_s2);
			dec_s3.ent.width      <= norm_sat(pw_s2);
			dec_s3.ent.height     <= norm_sat(ph_s2);
			dec_s3.ent.logit      <= logit_s2;
			dec_s3.ent.src_idx    <= cell_s2;
		end
	end

	always_ff @(posedge clk) begin
		gl_s1    <= {cx[17], cx} - {{3{sxh16[15]}}, sxh16};
		gt_s1    <= {cy[17], cy} - {{3{syh16[15]}}, syh16};
		gw_s1    <= {{3{sxf16[15]}}, sxf16};
		gh_s1    <= {{3{syf16[15]}}, syf16};
		cand_s1  <= heat_logit >= conf_thr;
		last_s1  <= last_cell;
		logit_s1 <= heat_logit;
		cell_s1  <= cell_d[15:0];

		pl_s2    <= gl_s1 * $signed({1'b0, inv_w});
		pt_s2    <= gt_s1 * $signed({1'b0, inv_h});
		pw_s2    <= gw_s1 * $signed({1'b0, inv_w});
		ph_s2    <= gh_s1 * $signed({1'b0, inv_h});
		cand_s2  <= cand_s1;
		last_s2  <= last_s1;
		logit_s2 <= logit_s1;
		cell_s2  <= cell_s1;
	end

	assign dec = dec_s3;

endmodule

@@ hdl/hbdn_iou.sv @@
module hbdn_iou (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  hbdn_pkg::cand_t   b,
	input  hbdn_pkg::cand_t   r,
	input  logic [16:0]       thr,
	output logic              hit
);
	import hbdn_pkg::*;

	logic signed [20:0] rr, br, rb, bb, lmax, tmax, rmin, bmin;
	logic signed [21:0] w_s1, h_s1;
	logic signed [19:0] bw_s1, bh_s1;
	logic               vld_s1;

	logic               vld_s2, neg_s2;
	logic signed [43:0] inter_s2;
	logic signed [39:0] ab_s2, ar_s2;

	logic               vld_s3, neg_s3;
	logic signed [43:0] inter_s3;
	logic signed [44:0] uni_s3;

	logic               vld_s4, neg_s4, upos_s4;
	logic [41:0]        inter_s4;
	logic [36:0]        plo_s4, phi_s4;
	logic [59:0]        lhs, rhs;

	assign rr   = {r.left[19], r.left} + {r.width[19], r.width};
	assign br   = {b.left[19], b.left} + {b.width[19], b.width};
	assign rb   = {r.top[19], r.top} + {r.height[19], r.height};
	assign bb   = {b.top[19], b.top} + {b.height[19], b.height};
	assign lmax = (r.left > b.left) ? {r.left[19], r.left} : {b.left[19], b.left};
	assign tmax = (r.top > b.top) ? {r.top[19], r.top} : {b.top[19], b.top};
	assign rmin = (rr < br) ? rr : br;
	assign bmin = (rb < bb) ? rb : bb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		w_s1  <= {rmin[20], rmin} - {lmax[20], lmax};
		h_s1  <= {bmin[20], bmin} - {tmax[20], tmax};
		bw_s1 <= b.width;
		bh_s1 <= b.height;

		neg_s2   <= w_s1[21] | h_s1[21];
		inter_s2 <= w_s1 * h_s1;
		ab_s2    <= bw_s1 * bh_s1;
		ar_s2    <= r.width * r.height;

		neg_s3   <= neg_s2;
		inter_s3 <= inter_s2;
		uni_s3   <= {{5{ar_s2[39]}}, ar_s2} + {{5{ab_s2[39]}}, ab_s2} - {inter_s2[43], inter_s2};

		neg_s4   <= neg_s3;
		upos_s4  <= !uni_s3[44] && (uni_s3 != '0);
		inter_s4 <= inter_s3[41:0];
		plo_s4   <= thr * uni_s3[19:0];
		phi_s4   <= thr * uni_s3[39:20];
	end

	// inter * 2^16 >= thr * union
	assign lhs = {2'b00, inter_s4, 16'h0000};
	assign rhs = {3'b000, phi_s4, 20'h00000} + {23'd0, plo_s4};
	assign hit = vld_s4 && (neg_s4 ? (thr == 17'd0) : (upos_s4 && (lhs >= rhs)));

endmodule

@@ hdl/heatmap_box_decode_nms.sv @@
// Cells enter one per cycle while busy is low; decode registers a cell 3 times before insertion.
// After the last cell, NMS pops one suppressed candidate per cycle, and for each kept box
// the overlap check rotates the 64-cell chain twice.
// A kept box is strobed once the next kept box or the list end is found; the final
// result is strobed from S_DONE, entered once the head cell is seen empty. busy holds off start.
// Results are one-cycle strobes, receiver cannot stall; reset loads default config, empties list.
module heatmap_box_decode_nms (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [7:0] heat_logit,
	input  logic signed [7:0] offset_x,
	input  logic signed [7:0] offset_y,
	input  logic signed [7:0] size_x,
	input  logic signed [7:0] size_y,
	input  logic              last_cell,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	output logic              result_strobe,
	output logic              box_valid,
	output logic signed [19:0] box_left,
	output logic signed [19:0] box_top,
	output logic signed [19:0] box_width,
	output logic signed [19:0] box_height,
	output logic [15:0]       score,
	output logic [15:0]       cell_index,
	output logic              overflow,
	output logic              last
);
	import hbdn_pkg::*;

	logic signed [7:0] conf_thr_q;
	logic [16:0]       nms_thr_q;
	logic [23:0]       inv_w_q, inv_h_q;
	logic [8:0]        grid_w_q, grid_h_q;
	logic [2:0]        ofs_frac_q, siz_frac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_thr_q <= -8'sd6;
			nms_thr_q  <= 17'd26214;
			inv_w_q    <= 24'd27962;
			inv_h_q    <= 24'd27962;
			grid_w_q   <= 9'd152;
			grid_h_q   <= 9'd152;
			ofs_frac_q <= 3'd4;
			siz_frac_q <= 3'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONF_THR: conf_thr_q <= cfg_data[7:0];
				CFG_NMS_THR:  nms_thr_q  <= cfg_data[16:0];
				CFG_INV_W:    inv_w_q    <= cfg_data;
				CFG_INV_H:    inv_h_q    <= cfg_data;
				CFG_GRID_W:   grid_w_q   <= cfg_data[8:0];
				CFG_GRID_H:   grid_h_q   <= cfg_data[8:0];
				CFG_OFS_FRAC: ofs_frac_q <= cfg_data[2:0];
				CFG_SIZ_FRAC: siz_frac_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	logic take;
	logic busy_q;
	dec_t dec;

	assign take = start && !busy_q;
	assign busy = busy_q;

	hbdn_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.heat_logit (heat_logit),
		.offset_x   (offset_x),
		.offset_y   (offset_y),
		.size_x     (size_x),
		.size_y     (size_y),
		.last_cell  (last_cell),
		.conf_thr   (conf_thr_q),
		.inv_w      (inv_w_q),
		.inv_h      (inv_h_q),
		.grid_w     (grid_w_q),
		.grid_h     (grid_h_q),
		.ofs_frac   (ofs_frac_q),
		.siz_frac   (siz_frac_q),
		.dec        (dec)
	);

	nms_state_t state_q;
	chain_op_t  op;
	logic [ROT_W-1:0] rot_q;
	cand_t pend_q;
	logic  pend_vld_q;
	logic  dropped_q;
	logic  hit;

	cand_t ent   [NCAND];
	logic  above [NCAND];
	cand_t prev0;
	cand_t tail_next;

	always_comb begin
		prev0 = dec.ent;
		prev0.vld = 1'b1;
		tail_next = ent[0];
		if (op == OP_POP)
			tail_next.vld = 1'b0;
	end

	for (genvar k = 0; k < NCAND; k++) begin : g_chain
		hbdn_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.new_ent    (dec.ent),
			.prev_ent   ((k == 0) ? prev0 : ent[(k == 0) ? 0 : k - 1]),
			.prev_above ((k == 0) ? 1'b0 : above[(k == 0) ? 0 : k - 1]),
			.next_ent   ((k == NCAND - 1) ? tail_next : ent[(k == NCAND - 1) ? 0 : k + 1]),
			.sup_hit    ((k == NCAND - 1 - CMP_LAT) ? hit : 1'b0),
			.ent        (ent[k]),
			.above      (above[k])
		);
	end

	// pend_q is the last kept box and the reference for the overlap pass
	hbdn_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    ((state_q == S_ROT) && (rot_q < ROT_W'(NCAND)) && ent[0].vld),
		.b      (ent[0]),
		.r      (pend_q),
		.thr    (nms_thr_q),
		.hit    (hit)
	);

	always_comb begin
		case (state_q)
			S_FILL:  op = (dec.vld && dec.cand) ? OP_INS : OP_HOLD;
			S_HEAD:  op = ent[0].vld ? OP_POP : OP_HOLD;
			S_ROT:   op = OP_ROT;
			default: op = OP_HOLD;
		endcase
	end

	logic out_stb_d;
	logic out_last_d;
	logic out_box_d;

	always_comb begin
		out_stb_d  = 1'b0;
		out_last_d = 1'b0;
		out_box_d  = pend_vld_q;
		case (state_q)
			S_HEAD:  out_stb_d = ent[0].vld && !ent[0].sup && pend_vld_q;
			S_DONE: begin
				out_stb_d  = 1'b1;
				out_last_d = 1'b1;
			end
			default: out_stb_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_FILL;
			rot_q      <= '0;
			pend_vld_q <= 1'b0;
			dropped_q  <= 1'b0;
			busy_q     <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= out_stb_d;
			if (take && last_cell)
				busy_q <= 1'b1;
			case (state_q)
				S_FILL: begin
					if (op == OP_INS && ent[NCAND-1].vld)
						dropped_q <= 1'b1;
					if (dec.vld && dec.last)
						state_q <= S_HEAD;
				end
				S_HEAD: begin
					if (!ent[0].vld) begin
						state_q <= S_DONE;
					end else if (!ent[0].sup) begin
						pend_vld_q <= 1'b1;
						rot_q      <= '0;
						state_q    <= S_ROT;
					end
				end
				S_ROT: begin
					rot_q <= rot_q + 1'b1;
					if (rot_q == ROT_W'(ROT_CYCLES - 1))
						state_q <= S_HEAD;
				end
				S_DONE: begin
					pend_vld_q <= 1'b0;
					dropped_q  <= 1'b0;
					busy_q     <= 1'b0;
					state_q    <= S_FILL;
				end
				default: state_q <= S_FILL;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HEAD && ent[0].vld && !ent[0].sup)
			pend_q <= ent[0];
		if (out_stb_d) begin
			box_valid  <= out_box_d;
			box_left   <= out_box_d ? pend_q.left : '0;
			box_top    <= out_box_d ? pend_q.top : '0;
			box_width  <= out_box_d ? pend_q.width : '0;
			box_height <= out_box_d ? pend_q.height : '0;
			score      <= out_box_d ? SIG_TAB[$unsigned(pend_q.logit)] : '0;
			cell_index <= out_box_d ? pend_q.src_idx : '0;
			overflow   <= dropped_q;
			last       <= out_last_d;
		end
	end

endmodule
